>>> design/conv3x3_valid_stream_macros.svh
// Assertion macros shared by the conv3x3_valid_stream checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef CONV3X3_VALID_STREAM_MACROS_SVH
`define CONV3X3_VALID_STREAM_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define C3VS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define C3VS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset; the consequent
// is sampled after the edge that applied the reset.
`define C3VS_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/c3vs_pkg.sv
// Shared types and constants for the 3x3 valid-mode convolution stream.
// No dependencies; imported by every module of the block.
`default_nettype none

package c3vs_pkg;

    localparam int SIZE_W       = 11;
    localparam int KERNEL_W     = 48;
    localparam int BIAS_W       = 16;
    localparam int CFG_DATA_W   = 48;
    localparam int CFG_INDEX_W  = 3;
    localparam int SUM_W        = 40;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = 10;
    localparam int MIN_SIZE     = 3;
    localparam int WIN_FIRST    = 2;   // first row/column with a full window

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4,
        REG_BIAS_VALUE    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0]          image_width;
        logic [SIZE_W-1:0]          image_height;
        logic [KERNEL_W-1:0]        kernel_top;
        logic [KERNEL_W-1:0]        kernel_middle;
        logic [KERNEL_W-1:0]        kernel_bottom;
        logic signed [BIAS_W-1:0]   bias_value;
    } cfg_t;

    // Control carried with a pixel leaving the line buffer stage.
    typedef struct packed {
        logic valid;
        logic emit;        // window is complete, a result follows
        logic frame_end;   // last pixel of the frame
    } item_ctrl_t;

endpackage

`default_nettype wire

>>> design/c3vs_cfg_regs.sv
// Configuration register file: width, height, kernel rows and bias.
// Depends on c3vs_pkg.
`default_nettype none

module c3vs_cfg_regs
    import c3vs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[SIZE_W-1:0];
                REG_KERNEL_TOP:    cfg_next.kernel_top    = cfg_data[KERNEL_W-1:0];
                REG_KERNEL_MIDDLE: cfg_next.kernel_middle = cfg_data[KERNEL_W-1:0];
                REG_KERNEL_BOTTOM: cfg_next.kernel_bottom = cfg_data[KERNEL_W-1:0];
                REG_BIAS_VALUE:    cfg_next.bias_value    = cfg_data[BIAS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{image_width:  SIZE_W'(MIN_SIZE),
                         image_height: SIZE_W'(MIN_SIZE),
                         default:      '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/c3vs_line_buf.sv
// Input stage: position counters, two line memories and the stage-1 register.
// Depends on c3vs_pkg.
`default_nettype none

module c3vs_line_buf
    import c3vs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [PIXEL_BITS-1:0] pixel_value,
    input  logic                         frame_start,
    input  logic [SIZE_W-1:0]            image_width,
    input  logic [SIZE_W-1:0]            image_height,
    input  logic                         s2_ready,
    output item_ctrl_t                   s1_ctrl,
    output logic signed [PIXEL_BITS-1:0] s1_pixel,
    output logic signed [PIXEL_BITS-1:0] s1_row_a,
    output logic signed [PIXEL_BITS-1:0] s1_row_b
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WB    = COL_W + 1;

    logic [WB-1:0]     width_eff;
    logic [WB-1:0]     width_last;
    logic [SIZE_W-1:0] height_eff;
    logic [SIZE_W-1:0] height_last;

    logic [COL_W-1:0] col_reg, col_next, col_start, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_start, row_cur;
    logic             last_col, last_row, emit_cur;
    logic             accept, s1_move;

    logic                         s1_valid_reg;
    logic                         s1_emit_reg;
    logic                         s1_frame_end_reg;
    logic [COL_W-1:0]             s1_col_reg;
    logic signed [PIXEL_BITS-1:0] s1_pixel_reg;
    logic signed [PIXEL_BITS-1:0] row_a_reg;
    logic signed [PIXEL_BITS-1:0] row_b_reg;

    logic signed [PIXEL_BITS-1:0] line_a_mem [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] line_b_mem [MAX_WIDTH];

    // Clamp the frame size to the supported range.
    always_comb
    begin
        if (image_width < SIZE_W'(MIN_SIZE))
            width_eff = WB'(MIN_SIZE);
        else if (32'(image_width) > 32'(MAX_WIDTH))
            width_eff = WB'(MAX_WIDTH);
        else
            width_eff = WB'(image_width);

        if (image_height < SIZE_W'(MIN_SIZE))
            height_eff = SIZE_W'(MIN_SIZE);
        else if (32'(image_height) > 32'(HEIGHT_LIMIT))
            height_eff = SIZE_W'(HEIGHT_LIMIT);
        else
            height_eff = image_height;
    end

    assign width_last  = width_eff - WB'(1);
    assign height_last = height_eff - SIZE_W'(1);

    // Position of the incoming pixel.
    always_comb
    begin
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;
        col_cur   = ({1'b0, col_start} >= width_eff)  ? width_last[COL_W-1:0]  : col_start;
        row_cur   = ({1'b0, row_start} >= height_eff) ? height_last[ROW_W-1:0] : row_start;
        last_col  = ({1'b0, col_cur} == width_last);
        last_row  = ({1'b0, row_cur} == height_last);
        emit_cur  = (col_cur >= COL_W'(WIN_FIRST)) && (row_cur >= ROW_W'(WIN_FIRST));

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end
    end

    assign s1_move  = s1_valid_reg && s2_ready;
    assign in_stall = s1_valid_reg && !s2_ready;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s2_ready)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg      <= emit_cur;
            s1_frame_end_reg <= last_col && last_row;
            s1_col_reg       <= col_cur;
            s1_pixel_reg     <= pixel_value;
        end
    end

    // Row above: read old contents, then overwrite with the new pixel.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_a_reg           <= line_a_mem[col_cur];
            line_a_mem[col_cur] <= pixel_value;
        end
    end

    // Row two above: takes the displaced row-above value when stage 1 moves on.
    // Forward it when the next pixel lands on the same column (frame restart).
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (s1_move && (s1_col_reg == col_cur))
                row_b_reg <= row_a_reg;
            else
                row_b_reg <= line_b_mem[col_cur];
        end
        if (s1_move)
            line_b_mem[s1_col_reg] <= row_a_reg;
    end

    assign s1_ctrl  = '{valid: s1_valid_reg, emit: s1_emit_reg, frame_end: s1_frame_end_reg};
    assign s1_pixel = s1_pixel_reg;
    assign s1_row_a = row_a_reg;
    assign s1_row_b = row_b_reg;

endmodule

`default_nettype wire

>>> design/c3vs_mac.sv
// Window register, tap products, adder stages and the output register.
// Depends on c3vs_pkg.
`default_nettype none

module c3vs_mac
    import c3vs_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int TAP_BITS   = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  item_ctrl_t                   s1_ctrl,
    input  logic signed [PIXEL_BITS-1:0] s1_pixel,
    input  logic signed [PIXEL_BITS-1:0] s1_row_a,
    input  logic signed [PIXEL_BITS-1:0] s1_row_b,
    output logic                         s2_ready,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SUM_W-1:0]      conv_sum,
    output logic                         frame_end
);

    localparam int KX_W   = (3 * TAP_BITS > KERNEL_W) ? 3 * TAP_BITS : KERNEL_W;
    localparam int PROD_W = PIXEL_BITS + TAP_BITS;

    logic                         r2, r3, r4, r5;
    logic                         load2;
    logic                         v2_reg, v3_reg, v4_reg, v5_reg;
    logic                         fe2_reg, fe3_reg, fe4_reg, fe5_reg;

    logic signed [PIXEL_BITS-1:0] win_reg  [3][3];
    logic [KX_W-1:0]              krow     [3];
    logic signed [TAP_BITS-1:0]   tap      [3][3];
    logic signed [PROD_W-1:0]     prod     [3][3];
    logic signed [SUM_W-1:0]      prod_reg [3][3];
    logic signed [SUM_W-1:0]      rsum_reg [3];
    logic signed [SUM_W-1:0]      bias_ext;
    logic signed [SUM_W-1:0]      sum_reg;

    // Stage ready chain: a stage takes a new item when empty or draining.
    assign r5    = !v5_reg || !out_stall;
    assign r4    = !v4_reg || r5;
    assign r3    = !v3_reg || r4;
    assign r2    = !v2_reg || r3;
    assign load2 = s1_ctrl.valid && r2;

    assign s2_ready = r2;

    // Tap extraction, left tap in the low bits of each row.
    always_comb
    begin
        krow[0] = KX_W'(cfg.kernel_top);
        krow[1] = KX_W'(cfg.kernel_middle);
        krow[2] = KX_W'(cfg.kernel_bottom);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                tap[r][c]  = krow[r][c*TAP_BITS +: TAP_BITS];
                prod[r][c] = win_reg[r][c] * tap[r][c];
            end
        end
    end

    assign bias_ext = SUM_W'($signed(cfg.bias_value));

    // Window: every pixel shifts it, emitting or not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else if (load2)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= s1_row_b;
            win_reg[1][2] <= s1_row_a;
            win_reg[2][2] <= s1_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r2)
                v2_reg <= s1_ctrl.valid && s1_ctrl.emit;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
            if (r5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2)
            fe2_reg <= s1_ctrl.frame_end;
        if (r3 && v2_reg)
        begin
            fe3_reg <= fe2_reg;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= SUM_W'(prod[r][c]);
        end
        if (r4 && v3_reg)
        begin
            fe4_reg     <= fe3_reg;
            rsum_reg[0] <= prod_reg[0][0] + prod_reg[0][1] + prod_reg[0][2] + bias_ext;
            rsum_reg[1] <= prod_reg[1][0] + prod_reg[1][1] + prod_reg[1][2];
            rsum_reg[2] <= prod_reg[2][0] + prod_reg[2][1] + prod_reg[2][2];
        end
        if (r5 && v4_reg)
        begin
            fe5_reg <= fe4_reg;
            sum_reg <= rsum_reg[0] + rsum_reg[1] + rsum_reg[2];
        end
    end

    assign out_valid = v5_reg;
    assign conv_sum  = sum_reg;
    assign frame_end = fe5_reg;

endmodule

`default_nettype wire

>>> design/conv3x3_valid_stream.sv
// Top level of the streaming 3x3 valid-mode convolution.
// Depends on c3vs_pkg, c3vs_cfg_regs, c3vs_line_buf and c3vs_mac.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_write             cfg_index, cfg_data
//   in       in         in_valid / in_stall   pixel_value, frame_start
//   out      out        out_valid / out_stall conv_sum, frame_end
//
// One pixel per clock while in_stall is low. A result passes through five
// registers (line memory read, window, products, row sums, final sum), the
// first loaded on the edge that takes its pixel.
// Reset is asynchronous, active low; it clears counters, window and valids.
// The line memories are not cleared; every entry is written by row 0
// before a window uses it.
// Output stalls back up through the five stages; empty stages keep
// accepting, so in_stall rises only when every stage holds a transaction.
`default_nettype none

module conv3x3_valid_stream
    import c3vs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int TAP_BITS   = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_write,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // pixel input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [PIXEL_BITS-1:0] pixel_value,
    input  logic                         frame_start,
    // result output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SUM_W-1:0]      conv_sum,
    output logic                         frame_end
);

    cfg_t                         cfg;
    item_ctrl_t                   s1_ctrl;
    logic signed [PIXEL_BITS-1:0] s1_pixel;
    logic signed [PIXEL_BITS-1:0] s1_row_a;
    logic signed [PIXEL_BITS-1:0] s1_row_b;
    logic                         s2_ready;

    c3vs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Counters and line memories; stage 1 holds the pixel and its column.
    c3vs_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_value  (pixel_value),
        .frame_start  (frame_start),
        .image_width  (cfg.image_width),
        .image_height (cfg.image_height),
        .s2_ready     (s2_ready),
        .s1_ctrl      (s1_ctrl),
        .s1_pixel     (s1_pixel),
        .s1_row_a     (s1_row_a),
        .s1_row_b     (s1_row_b)
    );

    // Window shift, nine products, row sums, final sum.
    c3vs_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .TAP_BITS   (TAP_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s1_ctrl   (s1_ctrl),
        .s1_pixel  (s1_pixel),
        .s1_row_a  (s1_row_a),
        .s1_row_b  (s1_row_b),
        .s2_ready  (s2_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .conv_sum  (conv_sum),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire

>>> design/c3vs_checker.sv
// Port-level checks for conv3x3_valid_stream, bound to the top level.
// Depends on c3vs_pkg and conv3x3_valid_stream_macros.svh.
`default_nettype none

`include "conv3x3_valid_stream_macros.svh"

module c3vs_checker
    import c3vs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [SUM_W-1:0] conv_sum,
    input logic                    frame_end
);

    // A stalled result transaction holds its payload.
    `C3VS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(conv_sum) && $stable(frame_end), "stalled result changed")

    // A stalled input transaction stays offered.
    `C3VS_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid, "stalled input transaction dropped")

    // With the output free every stage drains, so input is never stalled.
    `C3VS_ASSERT_NOW(a_no_stall_when_free, !out_stall, !in_stall, "input stalled while output free")

    // Input stall only when a transaction is pending somewhere downstream.
    `C3VS_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid, "input stalled with no result pending")

    // Reset empties the pipeline.
    `C3VS_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid && !in_stall, "pipeline not empty in reset")

endmodule

bind conv3x3_valid_stream c3vs_checker u_c3vs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .conv_sum  (conv_sum),
    .frame_end (frame_end)
);

`default_nettype wire

>>> tb/sv/conv3x3_valid_stream_tb.sv
// Self-checking bench for conv3x3_valid_stream: a raster pixel stream against a
// cycle-free predictor of the 3x3 valid-mode window sum. Depends on c3vs_pkg and
// the conv3x3_valid_stream RTL; nothing else.
module conv3x3_valid_stream_tb;
    import c3vs_pkg::*;

    localparam int MAX_WIDTH   = 1024;
    localparam int PIXEL_BITS  = 16;
    localparam int TAP_BITS    = 16;
    localparam int PIPE_SETTLE = 10;    // 5-stage pipe plus margin
    localparam int RANDOM_ITEMS = 750;
    localparam int REPORT_LIMIT = 10;

    // Kinds of frames the random part mixes together.
    typedef enum int {
        FRAME_CLEAN,
        FRAME_TRUNCATED,
        FRAME_OVERRUN,
        FRAME_NOISE
    } frame_kind_t;

    // One expected output transaction.
    typedef struct packed {
        logic signed [SUM_W-1:0] total;
        logic                    frame_last;
    } conv_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [PIXEL_BITS-1:0] pixel_value = '0;
    logic                         frame_start = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SUM_W-1:0]      conv_sum;
    logic                         frame_end;

    // Percent of pixels preceded by an idle gap, and of cycles in which the receiver stalls.
    int idle_pct = 14;
    int mismatch_count = 0;

    conv_result_t expected_sums[$];

    // Register shadows, reset values of the block.
    logic [SIZE_W-1:0]        cur_width = SIZE_W'(MIN_SIZE);
    logic [SIZE_W-1:0]        cur_height = SIZE_W'(MIN_SIZE);
    logic [KERNEL_W-1:0]      kernel_rows [3] = '{default: '0};
    logic signed [BIAS_W-1:0] cur_bias = '0;

    // Predictor state: the two line stores, the window and the position.
    bit signed [PIXEL_BITS-1:0] row_above     [MAX_WIDTH];
    bit signed [PIXEL_BITS-1:0] row_two_above [MAX_WIDTH];
    bit signed [PIXEL_BITS-1:0] pix_window    [3][3];
    int col_pos = 0;
    int row_pos = 0;

    conv3x3_valid_stream #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .TAP_BITS   (TAP_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .conv_sum    (conv_sum),
        .frame_end   (frame_end)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure: one decision per cycle, never during reset.
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < idle_pct);
    end

    // Size registers below 3 act as 3, above the limit act as the limit.
    function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        return (v > hi) ? hi : int'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    // Half the time, fill the bits above a register's width with junk;
    // the block must ignore them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                        input int bits);
        if ($urandom_range(1) == 1)
            v |= rand48() & ~((48'd1 << bits) - 48'd1);
        return v;
    endfunction

    // Mostly uniform pixels, with the field extremes mixed in.
    function automatic logic signed [PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Advance the window by one accepted pixel and queue the window sum
    // when a full 3x3 window exists. Top tap row meets the oldest row,
    // left tap (low bits) meets the oldest column.
    function automatic void convolve_pixel(input logic signed [PIXEL_BITS-1:0] px,
                                           input logic fs);
        int w;
        int h;
        int col;
        int row;
        longint acc;
        conv_result_t res;
        w = clamp_size(cur_width, MAX_WIDTH);
        h = clamp_size(cur_height, HEIGHT_LIMIT);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // a shrink mid-frame can leave the counters past the new limits
        col = (col_pos >= w) ? w - 1 : col_pos;
        row = (row_pos >= h) ? h - 1 : row_pos;

        for (int r = 0; r < 3; r++)
        begin
            pix_window[r][0] = pix_window[r][1];
            pix_window[r][1] = pix_window[r][2];
        end
        pix_window[0][2]   = row_two_above[col];
        pix_window[1][2]   = row_above[col];
        pix_window[2][2]   = px;
        row_two_above[col] = row_above[col];
        row_above[col]     = px;

        if (row >= WIN_FIRST && col >= WIN_FIRST)
        begin
            acc = longint'(cur_bias);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    acc += longint'($signed(kernel_rows[r][TAP_BITS*c +: TAP_BITS]))
                         * longint'(pix_window[r][c]);
            res.total      = acc[SUM_W-1:0];
            res.frame_last = (col == w - 1) && (row == h - 1);
            expected_sums.push_back(res);
        end

        if (col == w - 1)
        begin
            col_pos = 0;
            row_pos = (row == h - 1) ? 0 : row + 1;
        end
        else
        begin
            col_pos = col + 1;
            row_pos = row;
        end
    endfunction

    // Register write; only called while nothing is in flight.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:   cur_width = data[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:  cur_height = data[SIZE_W-1:0];
            REG_KERNEL_TOP:    kernel_rows[0] = data[KERNEL_W-1:0];
            REG_KERNEL_MIDDLE: kernel_rows[1] = data[KERNEL_W-1:0];
            REG_KERNEL_BOTTOM: kernel_rows[2] = data[KERNEL_W-1:0];
            REG_BIAS_VALUE:    cur_bias = data[BIAS_W-1:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] width,
                             input logic [CFG_DATA_W-1:0] height,
                             input logic [CFG_DATA_W-1:0] k_top,
                             input logic [CFG_DATA_W-1:0] k_mid,
                             input logic [CFG_DATA_W-1:0] k_bot,
                             input logic [CFG_DATA_W-1:0] bias);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_KERNEL_TOP, k_top);
        write_reg(REG_KERNEL_MIDDLE, k_mid);
        write_reg(REG_KERNEL_BOTTOM, k_bot);
        write_reg(REG_BIAS_VALUE, bias);
    endtask

    // Push one pixel transaction. Valid stays high into the next call unless
    // an idle gap is drawn; the payload holds while the block stalls.
    task automatic send_pixel(input logic signed [PIXEL_BITS-1:0] px, input logic fs);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= px;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        convolve_pixel(px, fs);
    endtask

    // Stop sending, wait for every queued result, then let the pipe empty of
    // pixels that produce no result before any register is touched.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // One frame at the current sizes. force_start puts frame_start on the
    // first pixel even for an overrun frame (needed right after a resize).
    task automatic send_frame(input frame_kind_t kind, input bit force_start,
                              inout int sent);
        int len;
        logic fs;
        len = clamp_size(cur_width, MAX_WIDTH) * clamp_size(cur_height, HEIGHT_LIMIT);
        if (kind == FRAME_TRUNCATED)
            len = $urandom_range(1, len - 1);
        else if (kind == FRAME_NOISE)
            len = $urandom_range(1, 2 * len);
        for (int i = 0; i < len; i++)
        begin
            fs = (i == 0) && (kind != FRAME_OVERRUN || force_start);
            if (kind == FRAME_NOISE && $urandom_range(9) == 0)
                fs = 1'b1;
            send_pixel(pick_pixel(), fs);
            sent++;
        end
    endtask

    // Extreme taps, pixels and bias; sizes written as 0 clamp to 3x3, and
    // the second frame runs on without frame_start (counter wrap).
    task automatic test_extremes();
        logic signed [PIXEL_BITS-1:0] edge_pixels [5];
        edge_pixels = '{16'sh7FFF, 16'sh8000, -16'sd1, 16'sd0, 16'sd1};
        configure(48'd0, with_junk(48'd0, SIZE_W), 48'h8000_8000_8000,
                  48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7FFF);
        for (int i = 0; i < 9; i++)
            send_pixel(16'sh8000, i == 0);
        for (int i = 0; i < 9; i++)
            send_pixel(16'sh7FFF, 1'b0);
        drain();
        configure(48'd4, 48'd3, 48'h7FFF_8000_FFFF, 48'h0001_7FFF_8000,
                  48'h8000_FFFF_7FFF, with_junk(48'h8000, BIAS_W));
        for (int i = 0; i < 12; i++)
            send_pixel(edge_pixels[i % 5], i == 0);
        drain();
    endtask

    // frame_start in the middle of a row restarts the position counters.
    task automatic test_frame_restart();
        int sent;
        sent = 0;
        configure(48'd4, 48'd3, rand48(), rand48(), rand48(), 48'($urandom_range(16'hFFFF)));
        for (int i = 0; i < 6; i++)
            send_pixel(pick_pixel(), i == 0);
        send_frame(FRAME_CLEAN, 1'b1, sent);
        drain();
    endtask

    // Sizes rewritten mid-frame. The sender pauses until every result is in,
    // then width shrinks at row 2 column 2 (row ends there), and later grows
    // back within columns already written while height drops below the
    // current row (row clamps to the last one).
    task automatic test_resize_mid_frame();
        configure(48'd5, 48'd4, rand48(), rand48(), rand48(), 48'($urandom_range(16'hFFFF)));
        for (int i = 0; i < 12; i++)
            send_pixel(pick_pixel(), i == 0);
        drain();
        write_reg(REG_IMAGE_WIDTH, 48'd3);
        for (int i = 0; i < 3; i++)
            send_pixel(pick_pixel(), 1'b0);
        drain();
        write_reg(REG_IMAGE_WIDTH, 48'd5);
        write_reg(REG_IMAGE_HEIGHT, 48'd0);
        for (int i = 0; i < 3; i++)
            send_pixel(pick_pixel(), 1'b0);
        drain();
    endtask

    // Back-to-back transactions on both sides, no idles or stalls at all.
    task automatic test_full_rate();
        int sent;
        sent = 0;
        idle_pct = 0;
        configure(48'd8, 48'd6, rand48(), rand48(), rand48(), 48'($urandom_range(16'hFFFF)));
        for (int f = 0; f < 4; f++)
            send_frame(FRAME_CLEAN, 1'b1, sent);
        drain();
        idle_pct = 14;
    endtask

    // Over-range height acts as the height limit; only a short stretch from
    // frame start is sent.
    task automatic test_size_limits();
        configure(48'd3, 48'd2047, rand48(), rand48(), rand48(), 48'($urandom_range(16'hFFFF)));
        for (int i = 0; i < 15; i++)
            send_pixel(pick_pixel(), i == 0);
        drain();
    endtask

    // Random phases: new settings, then a few frames, mostly well formed.
    task automatic test_random();
        int sent;
        int kind;
        int frames;
        logic [CFG_DATA_W-1:0] taps [3];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            for (int r = 0; r < 3; r++)
                case ($urandom_range(5))
                    0: taps[r] = '0;
                    1: taps[r] = 48'h8000_8000_8000;
                    2: taps[r] = 48'h7FFF_7FFF_7FFF;
                    default: taps[r] = rand48();
                endcase
            configure(with_junk(48'($urandom_range(12)), SIZE_W),
                      with_junk(48'($urandom_range(8)), SIZE_W),
                      taps[0], taps[1], taps[2],
                      with_junk(48'($urandom_range(16'hFFFF)), BIAS_W));
            frames = $urandom_range(1, 3);
            for (int f = frames; f > 0; f--)
            begin
                kind = $urandom_range(9);
                // first frame after a resize always carries frame_start
                if (kind <= 6)
                    send_frame(FRAME_CLEAN, 1'b1, sent);
                else if (kind == 7)
                    send_frame(FRAME_TRUNCATED, 1'b1, sent);
                else if (kind == 8)
                    send_frame(FRAME_OVERRUN, f == frames, sent);
                else
                    send_frame(FRAME_NOISE, 1'b1, sent);
            end
            drain();
        end
    endtask

    // Compare each accepted output transaction with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        conv_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: result with none expected: conv_sum=%0d frame_end=%0b",
                             $realtime, conv_sum, frame_end);
                mismatch_count++;
            end
            else
            begin
                want = expected_sums.pop_front();
                if (conv_sum !== want.total || frame_end !== want.frame_last)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: mismatch conv_sum exp %0d got %0d, frame_end exp %0b got %0b",
                                 $realtime, want.total, conv_sum, want.frame_last, frame_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_frame_restart();
        test_resize_mid_frame();
        test_full_rate();
        test_size_limits();
        test_random();
        drain();

        if (mismatch_count == 0 && expected_sums.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/c3vs_pkg.sv
design/c3vs_cfg_regs.sv
design/c3vs_line_buf.sv
design/c3vs_mac.sv
design/conv3x3_valid_stream.sv
design/c3vs_checker.sv
tb/sv/conv3x3_valid_stream_tb.sv
